[src/b64n_pkg.sv]
// ----------------------------------------------------------------------------
// b64n_pkg
// Shared types, codes and constants for the base64url nonce decoder.
// ----------------------------------------------------------------------------
package b64n_pkg;

    localparam int NONCE_BYTES_DEF = 16;
    localparam int BYTE_INDEX_W    = 4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_CHAR = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_BAD_TAIL = 3'd3,
        ST_ZERO     = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic                    has_byte;
        logic [7:0]              data_byte;
        logic [BYTE_INDEX_W-1:0] byte_index;
        logic                    done_res;
        status_t                 status;
    } res_item_t;

    // alphabet lookup result
    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } sym_t;

endpackage

[src/b64n_char_map.sv]
// ----------------------------------------------------------------------------
// b64n_char_map
// URL-safe alphabet lookup: raw byte to 6-bit value plus a legal flag.
// ----------------------------------------------------------------------------
module b64n_char_map (
    input  logic [7:0]    char_code,
    output b64n_pkg::sym_t sym
);

    logic [7:0] diff;

    always_comb
    begin
        sym  = '0;
        diff = '0;
        priority if (char_code >= 8'h41 && char_code <= 8'h5a)
        begin
            diff      = char_code - 8'h41;
            sym.ok    = 1'b1;
            sym.value = diff[5:0];
        end
        else if (char_code >= 8'h61 && char_code <= 8'h7a)
        begin
            diff      = char_code - 8'h61 + 8'd26;
            sym.ok    = 1'b1;
            sym.value = diff[5:0];
        end
        else if (char_code >= 8'h30 && char_code <= 8'h39)
        begin
            diff      = char_code - 8'h30 + 8'd52;
            sym.ok    = 1'b1;
            sym.value = diff[5:0];
        end
        else if (char_code == 8'h2d)
        begin
            sym.ok    = 1'b1;
            sym.value = 6'd62;
        end
        else if (char_code == 8'h5f)
        begin
            sym.ok    = 1'b1;
            sym.value = 6'd63;
        end
        else
        begin
            sym = '0;
        end
    end

endmodule

[src/b64n_core.sv]
// ----------------------------------------------------------------------------
// b64n_core
// Decode state (bit buffer, counters, error flag) and next result item.
// ----------------------------------------------------------------------------
module b64n_core #(
    parameter int NONCE_BYTES = b64n_pkg::NONCE_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  b64n_pkg::char_item_t   item,
    output b64n_pkg::res_item_t    result
);

    localparam int TEXT_CHARS  = (NONCE_BYTES * 8 + 5) / 6;
    localparam int CHAR_SAT    = TEXT_CHARS + 1;
    localparam int TAIL_BITS   = TEXT_CHARS * 6 - NONCE_BYTES * 8;
    localparam int CHAR_CNT_W  = $clog2(CHAR_SAT + 1);
    localparam int BYTE_CNT_W  = $clog2(NONCE_BYTES + 1);

    b64n_pkg::sym_t sym;

    logic [5:0]            bit_store_reg, bit_store_next;
    logic [2:0]            bit_count_reg, bit_count_next;
    logic [CHAR_CNT_W-1:0] char_count_reg, char_count_next;
    logic [BYTE_CNT_W-1:0] byte_count_reg, byte_count_next;
    logic                  nonzero_reg, nonzero_next;
    logic                  error_reg, error_next;

    logic [11:0]           comb_bits;
    logic [3:0]            total;
    logic [3:0]            shift;
    logic                  ge8;
    logic [2:0]            new_count;
    logic [5:0]            keep_mask;
    logic [11:0]           shifted;
    logic                  take;
    logic                  send;

    logic [5:0]            store_upd;
    logic [2:0]            count_upd;
    logic [CHAR_CNT_W-1:0] char_upd;
    logic [BYTE_CNT_W-1:0] byte_upd;
    logic                  nonzero_upd;
    logic                  error_upd;

    b64n_char_map u_map (
        .char_code (item.char_code),
        .sym       (sym)
    );

    // bit gathering
    always_comb
    begin
        comb_bits = {bit_store_reg, sym.value};
        total     = {1'b0, bit_count_reg} + 4'd6;
        ge8       = (total >= 4'd8);
        shift     = total - 4'd8;
        shifted   = comb_bits >> shift;
        new_count = ge8 ? shift[2:0] : 3'd6;
        keep_mask = ~(6'h3f << new_count);
        take      = sym.ok && !error_reg;
        send      = take && ge8 && (byte_count_reg < BYTE_CNT_W'(NONCE_BYTES));
    end

    // updated state for this character
    always_comb
    begin
        store_upd   = bit_store_reg;
        count_upd   = bit_count_reg;
        byte_upd    = byte_count_reg;
        nonzero_upd = nonzero_reg;
        error_upd   = error_reg | !sym.ok;
        char_upd    = (char_count_reg < CHAR_CNT_W'(CHAR_SAT)) ?
                      char_count_reg + 1'b1 : char_count_reg;
        if (take)
        begin
            store_upd = comb_bits[5:0] & keep_mask;
            count_upd = new_count;
        end
        if (send)
        begin
            byte_upd    = byte_count_reg + 1'b1;
            nonzero_upd = nonzero_reg | (shifted[7:0] != 8'h00);
        end
    end

    // result item and verdict
    always_comb
    begin
        result            = '0;
        result.has_byte   = send;
        result.data_byte  = send ? shifted[7:0] : 8'h00;
        result.byte_index = send ? byte_count_reg[b64n_pkg::BYTE_INDEX_W-1:0] : '0;
        result.done_res   = item.last_char;
        result.status     = b64n_pkg::ST_OK;
        if (item.last_char)
        begin
            priority if (char_upd != CHAR_CNT_W'(TEXT_CHARS))
                result.status = b64n_pkg::ST_BAD_LEN;
            else if (error_upd)
                result.status = b64n_pkg::ST_BAD_CHAR;
            else if (byte_upd != BYTE_CNT_W'(NONCE_BYTES) ||
                     count_upd != 3'(TAIL_BITS) || store_upd != 6'h00)
                result.status = b64n_pkg::ST_BAD_TAIL;
            else if (!nonzero_upd)
                result.status = b64n_pkg::ST_ZERO;
            else
                result.status = b64n_pkg::ST_OK;
        end
    end

    // state clears after the last character
    always_comb
    begin
        bit_store_next  = bit_store_reg;
        bit_count_next  = bit_count_reg;
        char_count_next = char_count_reg;
        byte_count_next = byte_count_reg;
        nonzero_next    = nonzero_reg;
        error_next      = error_reg;
        if (accept)
        begin
            if (item.last_char)
            begin
                bit_store_next  = '0;
                bit_count_next  = '0;
                char_count_next = '0;
                byte_count_next = '0;
                nonzero_next    = 1'b0;
                error_next      = 1'b0;
            end
            else
            begin
                bit_store_next  = store_upd;
                bit_count_next  = count_upd;
                char_count_next = char_upd;
                byte_count_next = byte_upd;
                nonzero_next    = nonzero_upd;
                error_next      = error_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_store_reg  <= '0;
            bit_count_reg  <= '0;
            char_count_reg <= '0;
            byte_count_reg <= '0;
            nonzero_reg    <= 1'b0;
            error_reg      <= 1'b0;
        end
        else
        begin
            bit_store_reg  <= bit_store_next;
            bit_count_reg  <= bit_count_next;
            char_count_reg <= char_count_next;
            byte_count_reg <= byte_count_next;
            nonzero_reg    <= nonzero_next;
            error_reg      <= error_next;
        end
    end

    // buffer only ever holds an even number of leftover bits
    a_even_bits: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg[0] == 1'b0)
        else $error("odd bit count in decode buffer");

    a_byte_cap: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= BYTE_CNT_W'(NONCE_BYTES))
        else $error("byte count past nonce size");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.last_char |=>
            char_count_reg == '0 && byte_count_reg == '0 &&
            bit_count_reg == '0 && !error_reg && !nonzero_reg)
        else $error("state not cleared after last character");

    a_no_byte_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> !send)
        else $error("byte sent after bad character");

endmodule

[src/base64url_nonce_decoder.sv]
// ----------------------------------------------------------------------------
// base64url_nonce_decoder
// Streaming strict decoder for the unpadded base64url text of a nonce.
// The result of a character transfer appears on res_item in the cycle after it.
// Throughput: one character per cycle; the output register takes a new
// result whenever it is empty or its current result is being transferred.
// Reset: rst_n (async, active low) empties the output register and clears
// the bit buffer, counters, nonzero flag and error flag.
// ----------------------------------------------------------------------------
module base64url_nonce_decoder #(
    parameter int NONCE_BYTES = b64n_pkg::NONCE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // character channel
    input  logic                 char_valid,
    output logic                 char_stall,
    input  b64n_pkg::char_item_t char_item,
    // result channel
    output logic                 res_valid,
    input  logic                 res_stall,
    output b64n_pkg::res_item_t  res_item
);

    // Every character yields exactly one result, so the character side only
    // has to wait when the output register holds a result that is stalled.
    logic                accept;
    logic                res_valid_reg, res_valid_next;
    b64n_pkg::res_item_t res_item_reg, res_item_next;
    b64n_pkg::res_item_t core_result;

    assign char_stall = res_valid_reg && res_stall;
    assign accept     = char_valid && !char_stall;

    // The core holds all decode state and forms the result combinationally
    // from the state and the incoming character; state advances on transfer.
    b64n_core #(
        .NONCE_BYTES (NONCE_BYTES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (char_item),
        .result (core_result)
    );

    // output register: load on transfer, hold while stalled, else drain
    always_comb
    begin
        res_item_next  = res_item_reg;
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_item_next  = core_result;
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // verdict only appears on the final result of a text
    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.done_res |-> res_item.status == b64n_pkg::ST_OK)
        else $error("status set on a non-final result");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.has_byte |->
            res_item.data_byte == 8'h00 && res_item.byte_index == '0)
        else $error("byte fields set without a byte");

    // a character transfer always lands in the output register
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid)
        else $error("character transfer produced no result");

endmodule

[bench/tb_base64url_nonce_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64url_nonce_decoder
// Self-checking bench for the base64url nonce decoder. Texts of characters
// (well-formed, all-zero, bad tail, bad character, short, long, noise) are
// fed one transfer at a time. A scoreboard class predicts every result
// and compares each received result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_base64url_nonce_decoder;

    localparam int ITEMS      = 1900;
    localparam int QUIET_TAIL = 300;     // last characters sent with no idling
    localparam int HOLD_LEN   = 120;     // long receiver hold-off, in cycles
    localparam int LIMIT      = 300000;  // cycle limit for the whole run
    localparam int TEXT_LEN   = 22;
    localparam int EDGE_SYMS [8] = '{0, 25, 26, 51, 52, 61, 62, 63};

    typedef enum int {
        TXT_VALID, TXT_ZERO, TXT_TAIL, TXT_BAD, TXT_SHORT, TXT_LONG, TXT_NOISE
    } text_kind_t;

    // ------------------------------------------------------------------------
    // Decoder state mirror, expected results and checking
    // ------------------------------------------------------------------------
    class nonce_scoreboard;
        b64n_pkg::res_item_t exp_q [$];
        logic [9:0] stash;        // leftover bits, right-aligned
        int         stash_bits;
        int         chars_seen;   // saturates at 23
        int         bytes_out;
        bit         saw_nonzero;
        bit         bad_seen;
        int         errors;
        int         results;
        int         bytes_checked;
        int         verdicts [5];

        function int sym_value(logic [7:0] c);
            if (c >= "A" && c <= "Z") return c - "A";
            if (c >= "a" && c <= "z") return c - "a" + 26;
            if (c >= "0" && c <= "9") return c - "0" + 52;
            if (c == "-") return 62;
            if (c == "_") return 63;
            return 64;
        endfunction

        function void clear_text();
            stash       = '0;
            stash_bits  = 0;
            chars_seen  = 0;
            bytes_out   = 0;
            saw_nonzero = 0;
            bad_seen    = 0;
        endfunction

        // accepted character: advance the mirror and queue its result
        function void note_char(b64n_pkg::char_item_t it);
            int                  sym;
            int                  total;
            logic [11:0]         comb;
            b64n_pkg::res_item_t r;
            r        = '0;
            r.status = b64n_pkg::ST_OK;
            sym      = sym_value(it.char_code);
            if (chars_seen < TEXT_LEN + 1) chars_seen++;
            if (sym > 63)
            begin
                bad_seen = 1;
            end
            else if (!bad_seen)
            begin
                total = stash_bits + 6;
                comb  = {stash[5:0], sym[5:0]};
                if (total >= 8)
                begin
                    total -= 8;
                    if (bytes_out < b64n_pkg::NONCE_BYTES_DEF)
                    begin
                        r.data_byte  = 8'(comb >> total);
                        r.byte_index = bytes_out[3:0];
                        r.has_byte   = 1'b1;
                        if (r.data_byte != 0) saw_nonzero = 1;
                        bytes_out++;
                    end
                end
                stash_bits = total;
                stash      = 10'(comb & ((12'd1 << total) - 1));
            end
            if (it.last_char)
            begin
                r.done_res = 1'b1;
                if (chars_seen != TEXT_LEN)
                    r.status = b64n_pkg::ST_BAD_LEN;
                else if (bad_seen)
                    r.status = b64n_pkg::ST_BAD_CHAR;
                else if (bytes_out != b64n_pkg::NONCE_BYTES_DEF || stash_bits != 4 ||
                         stash[3:0] != 0)
                    r.status = b64n_pkg::ST_BAD_TAIL;
                else if (!saw_nonzero)
                    r.status = b64n_pkg::ST_ZERO;
                verdicts[r.status]++;
                clear_text();
            end
            exp_q = {exp_q, r};
        endfunction

        function void check_result(b64n_pkg::res_item_t got);
            b64n_pkg::res_item_t want;
            if (exp_q.size() == 0)
            begin
                $error("result with no character pending");
                errors++;
                return;
            end
            want = exp_q.pop_front();
            results++;
            if (want.has_byte) bytes_checked++;
            if (got.has_byte !== want.has_byte)
            begin
                $error("has_byte: expected %0d, got %0d", want.has_byte, got.has_byte);
                errors++;
            end
            if (got.data_byte !== want.data_byte)
            begin
                $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                errors++;
            end
            if (got.byte_index !== want.byte_index)
            begin
                $error("byte_index: expected %0d, got %0d",
                       want.byte_index, got.byte_index);
                errors++;
            end
            if (got.done_res !== want.done_res)
            begin
                $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction

        function int outstanding();
            return exp_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 char_valid;
    logic                 char_stall;
    b64n_pkg::char_item_t char_item;
    logic                 res_valid;
    logic                 res_stall;
    b64n_pkg::res_item_t  res_item;

    nonce_scoreboard sb;

    logic [7:0] text_q [$];     // characters of the text being built
    int         items_sent;
    int         texts_sent;
    bit         quiet;          // no idling on either side
    bit         tx_gappy;       // sender inserts idle bursts
    bit         hold_req;       // ask the receiver for a long hold-off

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    base64url_nonce_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

    // ------------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge. The input is
    // noted first so a result can never overtake its own prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && !char_stall) sb.note_char(char_item);
            if (res_valid && !res_stall) sb.check_result(res_item);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request,
    // counted here so the sender keeps pushing and the decoder backs up.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int burst_left;
        bit rx_busy;
        bit hold_done;
        hold_left  = 0;
        burst_left = 0;
        rx_busy    = 1;
        hold_done  = 0;
        res_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1;
            end
            if ($urandom_range(0, 63) == 0) rx_busy = !rx_busy;
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else if (!quiet && burst_left > 0)
            begin
                res_stall <= 1'b1;
                burst_left--;
            end
            else if (!quiet && rx_busy && $urandom_range(0, 7) == 0)
            begin
                res_stall  <= 1'b1;
                burst_left = $urandom_range(0, 11);
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] sym_char(int v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return "-";
        return "_";
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (sb.sym_value(c) <= 63) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // append one character to the text being built
    function automatic void add_char(logic [7:0] c);
        text_q = {text_q, c};
    endfunction

    // one character transfer, with an optional idle burst in front
    task automatic put_char(input logic [7:0] code, input logic last);
        int gap;
        if (!quiet && tx_gappy && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            char_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        char_valid <= 1'b1;
        char_item  <= '{char_code: code, last_char: last};
        do @(posedge clk); while (char_stall);
        items_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            put_char(text_q[i], i == text_q.size() - 1);
        texts_sent++;
    endtask

    // wait until every predicted result has been received
    task automatic drain();
        @(negedge clk);
        char_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    task automatic build_text(input text_kind_t kind, input bit edge_pos);
        int len;
        int pos;
        text_q.delete();
        case (kind)
            TXT_VALID:
            begin
                for (int i = 0; i < TEXT_LEN - 1; i++)
                    add_char(sym_char($urandom_range(0, 63)));
                add_char(sym_char($urandom_range(0, 3) * 16));
            end
            TXT_ZERO:
            begin
                for (int i = 0; i < TEXT_LEN; i++) add_char("A");
            end
            TXT_TAIL:
            begin
                for (int i = 0; i < TEXT_LEN - 1; i++)
                    add_char(sym_char($urandom_range(0, 63)));
                add_char(sym_char($urandom_range(0, 3) * 16 + $urandom_range(1, 15)));
            end
            TXT_BAD:
            begin
                for (int i = 0; i < TEXT_LEN; i++)
                    add_char(sym_char($urandom_range(0, 63)));
                // bad character on the last one the first time through
                pos = edge_pos ? TEXT_LEN - 1 : $urandom_range(0, TEXT_LEN - 1);
                text_q[pos] = bad_char();
            end
            TXT_SHORT, TXT_LONG:
            begin
                len = (kind == TXT_SHORT) ? $urandom_range(1, TEXT_LEN - 1)
                                          : $urandom_range(TEXT_LEN + 1, 40);
                for (int i = 0; i < len; i++)
                    add_char(sym_char($urandom_range(0, 63)));
            end
            default:
            begin
                len = $urandom_range(1, 30);
                for (int i = 0; i < len; i++)
                    add_char($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                  : sym_char($urandom_range(0, 63)));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        text_kind_t kind;
        int         pick;
        sb         = new();
        sb.clear_text();
        clk        = 1'b0;
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_item  = '0;
        quiet      = 0;
        tx_gappy   = 1;
        hold_req   = 0;
        items_sent = 0;
        texts_sent = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: every alphabet edge in one valid text, then lone bad bytes
        text_q.delete();
        for (int i = 0; i < TEXT_LEN - 1; i++) add_char(sym_char(EDGE_SYMS[i % 8]));
        add_char(sym_char(16));
        send_text();
        text_q.delete();
        add_char(8'h00);
        send_text();
        text_q.delete();
        add_char(8'hff);
        send_text();
        // standard base64 symbols are rejected
        text_q.delete();
        add_char("+");
        add_char("/");
        add_char("=");
        send_text();
        drain();

        // random texts, well-formed ones the most common kind; the first pass hits every kind
        while (items_sent < ITEMS)
        begin
            if (texts_sent < 11)
            begin
                kind = text_kind_t'(texts_sent - 4);
            end
            else
            begin
                pick = $urandom_range(0, 15);
                kind = (pick < 7)  ? TXT_VALID :
                       (pick == 7) ? TXT_ZERO  :
                       (pick < 10) ? TXT_TAIL  :
                       (pick < 12) ? TXT_BAD   :
                       (pick == 12) ? TXT_SHORT :
                       (pick == 13) ? TXT_LONG  : TXT_NOISE;
            end
            if (texts_sent == 20) hold_req = 1;
            if (texts_sent % 25 == 24) drain();
            if (items_sent >= ITEMS - QUIET_TAIL) quiet = 1;
            if ($urandom_range(0, 3) == 0) tx_gappy = !tx_gappy;
            build_text(kind, texts_sent < 11);
            send_text();
        end

        drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d characters in %0d texts, %0d results, %0d bytes checked.",
                 items_sent, texts_sent, sb.results, sb.bytes_checked);
        $display("Verdicts ok/bad char/bad length/bad tail/all zero: %0d/%0d/%0d/%0d/%0d",
                 sb.verdicts[b64n_pkg::ST_OK], sb.verdicts[b64n_pkg::ST_BAD_CHAR],
                 sb.verdicts[b64n_pkg::ST_BAD_LEN], sb.verdicts[b64n_pkg::ST_BAD_TAIL],
                 sb.verdicts[b64n_pkg::ST_ZERO]);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
src/b64n_pkg.sv
src/b64n_char_map.sv
src/b64n_core.sv
src/base64url_nonce_decoder.sv
bench/tb_base64url_nonce_decoder.sv
